@@ rtl/pmst_pkg.sv @@
// ----------------------------------------------------------------------------
// pmst_pkg
// Shared constants and types of the spanning tree unit.
// ----------------------------------------------------------------------------
package pmst_pkg;
  localparam int MaxNodes  = 64;
  localparam int NodeW     = $clog2(MaxNodes);
  localparam int CountW    = 7;
  localparam int CostW     = 20;
  localparam int TotalW    = 26;
  localparam int TabDepth  = MaxNodes * MaxNodes;
  localparam int TabAw     = 2 * NodeW;
  localparam logic [CostW-1:0] InfCost = CostW'(1000000);

  typedef enum logic [1:0] {
    OpLoad  = 2'd0,
    OpRun   = 2'd1,
    OpClear = 2'd2,
    OpNone  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    StIdle, StLoadRd, StLoadWr, StClear, StInit, StScan, StScanEnd,
    StRelax, StRelaxEnd, StFinal
  } state_e;

  typedef struct packed {
    logic             we;
    logic [TabAw-1:0] waddr;
    logic [CostW-1:0] wdata;
    logic [TabAw-1:0] raddr;
  } tab_req_t;
endpackage

@@ rtl/pmst_cost_ram.sv @@
// ----------------------------------------------------------------------------
// pmst_cost_ram
// Cost table memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module pmst_cost_ram (
  input  logic                     clk_i,
  input  pmst_pkg::tab_req_t       req_i,
  output logic [pmst_pkg::CostW-1:0] rdata_o
);
  import pmst_pkg::*;
  logic [CostW-1:0] mem [TabDepth];
  always_ff @(posedge clk_i) begin
    if (req_i.we) mem[req_i.waddr] <= req_i.wdata;
    rdata_o <= mem[req_i.raddr];
  end
endmodule

@@ rtl/pmst_node_ram.sv @@
// ----------------------------------------------------------------------------
// pmst_node_ram
// Per-node key and parent memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module pmst_node_ram (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [pmst_pkg::NodeW-1:0]    waddr_i,
  input  logic [pmst_pkg::CostW+pmst_pkg::NodeW-1:0] wdata_i,
  input  logic [pmst_pkg::NodeW-1:0]    raddr_i,
  output logic [pmst_pkg::CostW+pmst_pkg::NodeW-1:0] rdata_o
);
  import pmst_pkg::*;
  logic [CostW+NodeW-1:0] mem [MaxNodes];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

@@ rtl/prim_minimum_spanning_tree_unit.sv @@
// ----------------------------------------------------------------------------
// prim_minimum_spanning_tree_unit
// Dense Prim spanning tree over a memory-held cost table.
// ----------------------------------------------------------------------------
// Usage: drive op_i and the edge fields with start_i while busy_o is low; the
// command transfers on that edge. node_count_we_i/node_count_i write the node
// count; the user must write it only while idle, the block does not enforce
// it. Results appear on the result ports for one cycle with result_valid_o;
// the receiver cannot stall them. A load reads the table entry, then compares
// and writes back. A clear sweeps all 4096 table entries, one per cycle. A run
// initializes n node entries, then per tree step scans n keys and relaxes the
// chosen row. Every tree edge gives one result, then the summary item with
// last_o. After reset all 4096 table entries are swept to infinity with busy_o
// high; the node count resets to 64.
// ----------------------------------------------------------------------------
module prim_minimum_spanning_tree_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   op_i,
  input  logic [5:0]                   src_node_i,
  input  logic [5:0]                   dst_node_i,
  input  logic [19:0]                  edge_cost_i,
  input  logic                         node_count_we_i,
  input  logic [6:0]                   node_count_i,
  output logic                         result_valid_o,
  output logic [5:0]                   from_node_o,
  output logic [5:0]                   to_node_o,
  output logic [19:0]                  added_cost_o,
  output logic [25:0]                  total_cost_o,
  output logic                         all_reached_o,
  output logic                         last_o
);
  import pmst_pkg::*;

  state_e state_q, state_d;
  logic [CountW-1:0] ncfg_q;
  logic [TabAw:0]    cnt_q, cnt_d;
  logic [NodeW:0]    idx_q, idx_d;
  logic [NodeW-1:0]  u_q, u_d, s_q, d_q;
  logic [CostW-1:0]  c_q, best_q, best_d;
  logic              found_q, found_d;
  logic [MaxNodes-1:0] tree_q, tree_d;
  logic [TotalW-1:0] sum_q, sum_d;
  logic [NodeW:0]    joined_q, joined_d;
  logic [NodeW:0]    n_w;
  logic              rv_q;
  logic [NodeW-1:0]  ri_q;

  tab_req_t treq;
  logic [CostW-1:0] tdata;
  logic nwe;
  logic [NodeW-1:0] nwaddr, nraddr;
  logic [CostW+NodeW-1:0] nwdata, nrdata;
  logic [CostW-1:0] nkey;
  logic [NodeW-1:0] npar;
  logic out_v;
  logic [NodeW-1:0] out_from, out_to;
  logic [CostW-1:0] out_add;
  logic out_last;

  pmst_cost_ram u_tab (.clk_i, .req_i(treq), .rdata_o(tdata));
  pmst_node_ram u_node (.clk_i, .we_i(nwe), .waddr_i(nwaddr), .wdata_i(nwdata),
                        .raddr_i(nraddr), .rdata_o(nrdata));

  assign nkey = nrdata[CostW+NodeW-1:NodeW];
  assign npar = nrdata[NodeW-1:0];

  always_comb begin
    if (ncfg_q == '0) n_w = (NodeW+1)'(1);
    else if (ncfg_q > CountW'(MaxNodes)) n_w = (NodeW+1)'(MaxNodes);
    else n_w = (NodeW+1)'(ncfg_q);
  end

  assign busy_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; idx_d = idx_q; u_d = u_q;
    best_d = best_q; found_d = found_q; tree_d = tree_q; sum_d = sum_q;
    joined_d = joined_q;
    treq = '0; nwe = 1'b0; nwaddr = '0; nwdata = '0; nraddr = '0;
    out_v = 1'b0; out_from = '0; out_to = '0; out_add = '0; out_last = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          unique case (op_e'(op_i))
            OpLoad: if (src_node_i != dst_node_i) state_d = StLoadRd;
            OpRun: begin
              cnt_d = '0; state_d = StInit;
            end
            OpClear: begin
              cnt_d = '0; state_d = StClear;
            end
            default: state_d = StIdle;
          endcase
        end
      end
      StLoadRd: begin
        treq.raddr = {s_q, d_q}; state_d = StLoadWr;
      end
      StLoadWr: begin
        treq.we = (c_q < tdata); treq.waddr = {s_q, d_q}; treq.wdata = c_q;
        state_d = StIdle;
      end
      StClear: begin
        treq.we = 1'b1; treq.waddr = cnt_q[TabAw-1:0]; treq.wdata = InfCost;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (TabAw+1)'(TabDepth - 1)) state_d = StIdle;
      end
      StInit: begin
        nwe = 1'b1; nwaddr = cnt_q[NodeW-1:0];
        nwdata = {(cnt_q == '0) ? CostW'(0) : InfCost, {NodeW{1'b1}}};
        cnt_d = cnt_q + 1'b1;
        tree_d = '0; sum_d = '0; joined_d = '0;
        if (cnt_q[NodeW:0] == n_w - 1'b1) begin
          idx_d = '0; best_d = InfCost; found_d = 1'b0; state_d = StScan;
        end
      end
      StScan: begin
        nraddr = idx_q[NodeW-1:0];
        if (rv_q && !tree_q[ri_q] && nkey < best_q) begin
          best_d = nkey; u_d = ri_q; found_d = 1'b1;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == n_w - 1'b1) state_d = StScanEnd;
      end
      StScanEnd: begin
        if (rv_q && !tree_q[ri_q] && nkey < best_q) begin
          best_d = nkey; u_d = ri_q; found_d = 1'b1;
        end
        nraddr = (rv_q && !tree_q[ri_q] && nkey < best_q) ? ri_q : u_q;
        if (!(found_q || (rv_q && !tree_q[ri_q] && nkey < best_q)))
          state_d = StFinal;
        else begin
          idx_d = '0; state_d = StRelax;
        end
      end
      StRelax: begin
        if (idx_q == '0) begin
          tree_d[u_q] = 1'b1; joined_d = joined_q + 1'b1;
          if (u_q != '0) begin
            sum_d = sum_q + TotalW'(nkey);
            out_v = 1'b1; out_from = npar; out_to = u_q; out_add = nkey;
          end
        end
        treq.raddr = {u_q, idx_q[NodeW-1:0]};
        nraddr = idx_q[NodeW-1:0];
        if (rv_q && !tree_q[ri_q] && ri_q != u_q && tdata < nkey) begin
          nwe = 1'b1; nwaddr = ri_q; nwdata = {tdata, u_q};
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == n_w - 1'b1) state_d = StRelaxEnd;
      end
      StRelaxEnd: begin
        if (!tree_q[ri_q] && tdata < nkey) begin
          nwe = 1'b1; nwaddr = ri_q; nwdata = {tdata, u_q};
        end
        idx_d = '0; best_d = InfCost; found_d = 1'b0;
        if (joined_q == n_w) state_d = StFinal;
        else state_d = StScan;
      end
      StFinal: begin
        out_v = 1'b1; out_last = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // node read issued in StScanEnd returns node u's own entry for the result in StRelax idx 0;
  // data path keeps the read index, registered alongside the read data, in ri_q
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; cnt_q <= '0; idx_q <= '0; u_q <= '0; best_q <= InfCost;
      found_q <= 1'b0; tree_q <= '0; sum_q <= '0; joined_q <= '0; ncfg_q <= 7'd64;
      rv_q <= 1'b0; ri_q <= '0; result_valid_o <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; idx_q <= idx_d; u_q <= u_d;
      best_q <= best_d; found_q <= found_d; tree_q <= tree_d; sum_q <= sum_d;
      joined_q <= joined_d;
      if (node_count_we_i) ncfg_q <= node_count_i;
      rv_q <= (state_q == StScan) || (state_q == StRelax);
      ri_q <= nraddr;
      result_valid_o <= out_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle) begin
      s_q <= src_node_i; d_q <= dst_node_i; c_q <= edge_cost_i;
    end
    from_node_o <= out_from; to_node_o <= out_to; added_cost_o <= out_add;
    total_cost_o <= out_last ? sum_q : sum_d;
    all_reached_o <= out_last && (joined_q == n_w);
    last_o <= out_last;
  end
endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks the spanning tree unit against a cycle-free predictor of the cost
// table and of dense Prim's algorithm. Edge loads, clears, runs and unused
// commands are sent under several node counts and sender idling phases; every
// result transfer is compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module testbench;
  import pmst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0]  from_node;
    logic [5:0]  to_node;
    logic [19:0] added_cost;
    logic [25:0] total_cost;
    logic        all_reached;
    logic        last;
  } tree_res_t;

  typedef struct {
    op_e         op;
    logic [5:0]  src;
    logic [5:0]  dst;
    logic [19:0] cost;
    bit          chk;
    logic [25:0] exp_total;
    logic        exp_all;
  } cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  op_i = OpLoad;
  logic [5:0]  src_node_i = '0;
  logic [5:0]  dst_node_i = '0;
  logic [19:0] edge_cost_i = '0;
  logic        node_count_we_i = 1'b0;
  logic [6:0]  node_count_i = '0;
  logic        result_valid_o;
  logic [5:0]  from_node_o;
  logic [5:0]  to_node_o;
  logic [19:0] added_cost_o;
  logic [25:0] total_cost_o;
  logic        all_reached_o;
  logic        last_o;

  prim_minimum_spanning_tree_unit DUT (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [CostW-1:0] cost_tab [TabDepth];
  logic [6:0]       count_reg;
  tree_res_t        tree_q [$];
  int               errors = 0;
  int               cycles = 0;
  int               idle_pct = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    tree_res_t e;
    if (rst_ni && result_valid_o) begin
      if (tree_q.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        e = tree_q.pop_front();
        if (from_node_o !== e.from_node) begin
          $error("from_node exp %0d got %0d", e.from_node, from_node_o); errors++;
        end
        if (to_node_o !== e.to_node) begin
          $error("to_node exp %0d got %0d", e.to_node, to_node_o); errors++;
        end
        if (added_cost_o !== e.added_cost) begin
          $error("added_cost exp %0d got %0d", e.added_cost, added_cost_o); errors++;
        end
        if (total_cost_o !== e.total_cost) begin
          $error("total_cost exp %0d got %0d", e.total_cost, total_cost_o); errors++;
        end
        if (all_reached_o !== e.all_reached) begin
          $error("all_reached exp %0d got %0d", e.all_reached, all_reached_o); errors++;
        end
        if (last_o !== e.last) begin
          $error("last exp %0d got %0d", e.last, last_o); errors++;
        end
      end
    end
  end

  function automatic void clear_costs();
    foreach (cost_tab[i]) cost_tab[i] = InfCost;
  endfunction

  function automatic tree_res_t grow_tree();
    int n, u, joined;
    logic [CostW-1:0] key [MaxNodes];
    int parent [MaxNodes];
    bit done [MaxNodes];
    logic [CostW-1:0] best, c;
    logic [25:0] sum;
    tree_res_t r;
    n = (count_reg == 0) ? 1 : (count_reg > MaxNodes ? MaxNodes : count_reg);
    joined = 0;
    sum = '0;
    for (int i = 0; i < MaxNodes; i++) begin
      key[i] = InfCost; parent[i] = -1; done[i] = 1'b0;
    end
    key[0] = '0;
    for (int step = 0; step < n; step++) begin
      best = InfCost; u = n;
      for (int i = 0; i < n; i++)
        if (!done[i] && key[i] < best) begin
          best = key[i]; u = i;
        end
      if (u >= n) break;
      done[u] = 1'b1;
      joined++;
      if (parent[u] >= 0) begin
        sum = sum + 26'(key[u]);
        r = '{6'(parent[u]), 6'(u), key[u], sum, 1'b0, 1'b0};
        tree_q = {tree_q, r};
      end
      for (int i = 0; i < n; i++) begin
        c = cost_tab[u * MaxNodes + i];
        if (!done[i] && c < key[i]) begin
          key[i] = c; parent[i] = u;
        end
      end
    end
    r = '{6'd0, 6'd0, 20'd0, sum, 1'(joined == n), 1'b1};
    tree_q = {tree_q, r};
    return r;
  endfunction

  task automatic apply_cmd(cmd_t cmd);
    tree_res_t fin;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    start_i <= 1'b1;
    op_i <= cmd.op;
    src_node_i <= cmd.src;
    dst_node_i <= cmd.dst;
    edge_cost_i <= cmd.cost;
    do @(posedge clk_i); while (busy_o);
    case (cmd.op)
      OpLoad: begin
        if (cmd.src != cmd.dst && cmd.cost < cost_tab[{cmd.src, cmd.dst}])
          cost_tab[{cmd.src, cmd.dst}] = cmd.cost;
      end
      OpRun: begin
        fin = grow_tree();
        if (cmd.chk && (fin.total_cost !== cmd.exp_total || fin.all_reached !== cmd.exp_all)) begin
          $error("summary total/all_reached exp %0d/%0d got %0d/%0d", cmd.exp_total,
                 cmd.exp_all, fin.total_cost, fin.all_reached);
          errors++;
        end
      end
      OpClear: clear_costs();
      default: ;
    endcase
  endtask

  task automatic settle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (tree_q.size() != 0 || busy_o) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_count(logic [6:0] v);
    node_count_we_i <= 1'b1;
    node_count_i <= v;
    @(posedge clk_i);
    node_count_we_i <= 1'b0;
    count_reg = v;
  endtask

  function automatic cmd_t random_cmd(int n);
    cmd_t cmd;
    int r, lim;
    lim = (n < 1) ? 0 : (n > MaxNodes ? MaxNodes - 1 : n - 1);
    cmd = '{OpLoad, '0, '0, '0, 1'b0, '0, 1'b0};
    r = $urandom_range(99);
    if (r < 10) cmd.op = OpRun;
    else if (r < 11) cmd.op = OpClear;
    else if (r < 14) cmd.op = OpNone;
    if (r >= 90) begin
      cmd.src = 6'($urandom);
      cmd.dst = 6'($urandom);
      cmd.cost = 20'($urandom);
    end else begin
      cmd.src = 6'($urandom_range(lim));
      cmd.dst = 6'($urandom_range(lim));
      cmd.cost = ($urandom_range(3) == 0) ? 20'($urandom_range(999999)) :
                 20'($urandom_range(50));
    end
    return cmd;
  endfunction

  cmd_t directed [15] = '{
    '{OpRun,   6'd0,  6'd0,  20'd0,      1'b1, 26'd0, 1'b0},
    '{OpLoad,  6'd5,  6'd5,  20'd1,      1'b0, 26'd0, 1'b0},
    '{OpLoad,  6'd0,  6'd1,  20'd0,      1'b0, 26'd0, 1'b0},
    '{OpLoad,  6'd0,  6'd1,  20'd999999, 1'b0, 26'd0, 1'b0},
    '{OpLoad,  6'd1,  6'd2,  20'hFFFFF,  1'b0, 26'd0, 1'b0},
    '{OpLoad,  6'd1,  6'd3,  20'd1000000, 1'b0, 26'd0, 1'b0},
    '{OpLoad,  6'd63, 6'd0,  20'd7,      1'b0, 26'd0, 1'b0},
    '{OpLoad,  6'd0,  6'd63, 20'd999999, 1'b0, 26'd0, 1'b0},
    '{OpLoad,  6'd2,  6'd1,  20'd3,      1'b0, 26'd0, 1'b0},
    '{OpLoad,  6'd1,  6'd2,  20'd9,      1'b0, 26'd0, 1'b0},
    '{OpLoad,  6'd1,  6'd4,  20'd9,      1'b0, 26'd0, 1'b0},
    '{OpNone,  6'd63, 6'd63, 20'hFFFFF,  1'b0, 26'd0, 1'b0},
    '{OpRun,   6'd0,  6'd0,  20'd0,      1'b0, 26'd0, 1'b0},
    '{OpClear, 6'd0,  6'd0,  20'd0,      1'b0, 26'd0, 1'b0},
    '{OpRun,   6'd0,  6'd0,  20'd0,      1'b1, 26'd0, 1'b0}
  };

  int counts [10] = '{0, 1, 127, 2, 5, 8, 3, 64, 12, 6};

  initial begin
    clear_costs();
    count_reg = 7'd64;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    settle();
    foreach (directed[i]) apply_cmd(directed[i]);
    settle();
    write_count(7'd1);
    apply_cmd('{OpRun, 6'd0, 6'd0, 20'd0, 1'b1, 26'd0, 1'b1});
    settle();
    foreach (counts[p]) begin
      write_count(7'(counts[p]));
      case (p % 3)
        0: idle_pct = 0;
        1: idle_pct = 78;
        default: idle_pct = 38;
      endcase
      repeat (35) apply_cmd(random_cmd(counts[p]));
      apply_cmd('{OpRun, 6'd0, 6'd0, 20'd0, 1'b0, 26'd0, 1'b0});
      settle();
    end
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
